// File: rtl/ipfmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfmt_pkg: shared types and constants of the address text formatter
// Descriptor passed from the classifier to the text emitter, item kinds and
// the ASCII codes the emitter writes.
// ----------------------------------------------------------------------------
package ipfmt_pkg;

    localparam int ADDR_W = 128;

    // family codes on the input port
    localparam logic [1:0] FAM_V4 = 2'd1;
    localparam logic [1:0] FAM_V6 = 2'd2;

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_V4    = 2'd1,
        KIND_V6    = 2'd2
    } kind_t;

    // classified word: address plus the zero-group run to contract
    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        run_start;
        logic [3:0]        run_len;    // 0 when nothing is contracted
    } desc_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_HEX_A  = 8'h61;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

endpackage

// File: rtl/ip_address_text_formatter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_text_formatter_core: IPv4/IPv6 address to ASCII text
// Classifier, descriptor queue and character emitter.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a word is taken at a rising edge with start high and busy low.
//   address_family 1 gives dotted decimal from address_upper[63:32],
//   2 gives bracketed lower-case IPv6 with the longest zero run (two or more
//   groups, first on a tie) written as "::"; 0 and 3 give one NUL character
//   with empty_text set.
//   Output: one character per cycle while strobe is high; last_char marks the
//   final character of a word. The receiver cannot stall, so no word is lost.
//   A word is queued, loaded by the emitter when idle, then registered out.
//   Throughput: the emitter sequencer writes one character per cycle and
//   loads the next word only in its idle state, after the final character;
//   a word has up to 41 characters for IPv6, 7 to 15 for IPv4, 1 if empty.
//   busy is high while QUEUE_DEPTH words wait in the queue.
//   Reset empties the queue and the emitter; nothing needs a clearing pass.
// ----------------------------------------------------------------------------
module ip_address_text_formatter_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] address_upper,
    input  logic [63:0] address_lower,
    input  logic [1:0]  address_family,
    output logic        strobe,
    output logic [7:0]  text_char,
    output logic        last_char,
    output logic        empty_text
);

    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;
    ipfmt_pkg::desc_t wr_desc;
    ipfmt_pkg::desc_t head;

    assign busy = q_full;

    ipfmt_front u_front
    (
        .start          (start),
        .full           (q_full),
        .address_upper  (address_upper),
        .address_lower  (address_lower),
        .address_family (address_family),
        .push           (push),
        .desc           (wr_desc)
    );

    ipfmt_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_desc (wr_desc),
        .pop     (pop),
        .head    (head),
        .empty   (q_empty),
        .full    (q_full)
    );

    ipfmt_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .strobe     (strobe),
        .text_char  (text_char),
        .last_char  (last_char),
        .empty_text (empty_text)
    );

endmodule

// File: rtl/ipfmt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfmt_front: input classifier
// Takes a word on start/busy, decodes the family and finds the longest run of
// two or more zero groups (first run wins a tie) for the text emitter.
// ----------------------------------------------------------------------------
module ipfmt_front
(
    input  logic                 start,
    input  logic                 full,
    input  logic [63:0]          address_upper,
    input  logic [63:0]          address_lower,
    input  logic [1:0]           address_family,
    output logic                 push,
    output ipfmt_pkg::desc_t     desc
);

    typedef struct packed {
        logic [2:0] start;
        logic [3:0] len;
    } run_t;

    // bit g is set when 16-bit group g (group 0 most significant) is zero
    function automatic run_t zero_run(input logic [7:0] zf);
        run_t       best;
        logic [2:0] rs;
        logic [3:0] rl;
        best = '0;
        rs   = '0;
        rl   = '0;
        for (int g = 0; g < 8; g++)
        begin
            if (zf[g])
            begin
                if (rl == 4'd0)
                    rs = 3'(g);
                rl = rl + 4'd1;
            end
            if (!zf[g] || g == 7)
            begin
                if (rl >= 4'd2 && rl > best.len)
                begin
                    best.start = rs;
                    best.len   = rl;
                end
                rl = '0;
            end
        end
        return best;
    endfunction

    logic [ipfmt_pkg::ADDR_W-1:0] addr;
    logic [7:0]                   zero_flags;
    run_t                         run;

    assign addr = {address_upper, address_lower};
    assign push = start && !full;

    always_comb
    begin
        for (int g = 0; g < 8; g++)
            zero_flags[g] = (addr[ipfmt_pkg::ADDR_W-1-16*g -: 16] == 16'h0000);
    end

    assign run = zero_run(zero_flags);

    always_comb
    begin
        desc.addr      = addr;
        desc.run_start = run.start;
        desc.run_len   = run.len;
        unique case (address_family)
            ipfmt_pkg::FAM_V4: desc.kind = ipfmt_pkg::KIND_V4;
            ipfmt_pkg::FAM_V6: desc.kind = ipfmt_pkg::KIND_V6;
            default:           desc.kind = ipfmt_pkg::KIND_EMPTY;
        endcase
    end

endmodule

// File: rtl/ipfmt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfmt_queue: descriptor queue
// Short register FIFO between classifier and emitter; full drives busy.
// ----------------------------------------------------------------------------
module ipfmt_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ipfmt_pkg::desc_t wr_desc,
    input  logic             pop,
    output ipfmt_pkg::desc_t head,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipfmt_pkg::desc_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_desc;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> !full)
        else $error("push into full queue");

endmodule

// File: rtl/ipfmt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfmt_back: text emitter
// Pops one descriptor at a time and walks it as a sequencer, one character per
// cycle into the output register.
// ----------------------------------------------------------------------------
module ipfmt_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  ipfmt_pkg::desc_t head,
    input  logic             q_empty,
    output logic             pop,
    output logic             strobe,
    output logic [7:0]       text_char,
    output logic             last_char,
    output logic             empty_text
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_EMPTY    = 10'b00_0000_0010,
        ST_V4_DIG   = 10'b00_0000_0100,
        ST_V4_DOT   = 10'b00_0000_1000,
        ST_V6_OPEN  = 10'b00_0001_0000,
        ST_V6_LEAD  = 10'b00_0010_0000,
        ST_V6_HEX   = 10'b00_0100_0000,
        ST_V6_SEP   = 10'b00_1000_0000,
        ST_V6_DCOL  = 10'b01_0000_0000,
        ST_V6_CLOSE = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } dec_t;

    function automatic logic [15:0] grp_at(input logic [ipfmt_pkg::ADDR_W-1:0] a,
                                           input logic [2:0] i);
        logic [ipfmt_pkg::ADDR_W-1:0] sh;
        sh = a << {i, 4'b0000};
        return sh[ipfmt_pkg::ADDR_W-1 -: 16];
    endfunction

    function automatic logic [7:0] byte_at(input logic [ipfmt_pkg::ADDR_W-1:0] a,
                                           input logic [1:0] i);
        logic [ipfmt_pkg::ADDR_W-1:0] sh;
        sh = a << {i, 3'b000};
        return sh[ipfmt_pkg::ADDR_W-1 -: 8];
    endfunction

    // tens by reciprocal: (r * 205) >> 11 is exact for r < 100
    function automatic dec_t to_decimal(input logic [7:0] v);
        dec_t        d;
        logic [6:0]  r;
        logic [14:0] p;
        if (v >= 8'd200)
            d.hund = 2'd2;
        else if (v >= 8'd100)
            d.hund = 2'd1;
        else
            d.hund = 2'd0;
        r      = 7'(v - 8'({6'd0, d.hund} * 8'd100));
        p      = 15'({8'd0, r}) * 15'd205;
        d.tens = 4'(p >> 11);
        d.ones = 4'(r - 7'({3'd0, d.tens} * 7'd10));
        return d;
    endfunction

    function automatic logic [1:0] dec_lead(input logic [7:0] v);
        if (v >= 8'd100)
            return 2'd2;
        else if (v >= 8'd10)
            return 2'd1;
        return 2'd0;
    endfunction

    function automatic logic [1:0] hex_lead(input logic [15:0] g);
        if (g[15:12] != 4'h0)
            return 2'd3;
        else if (g[11:8] != 4'h0)
            return 2'd2;
        else if (g[7:4] != 4'h0)
            return 2'd1;
        return 2'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10)
            return ipfmt_pkg::CH_ZERO + {4'd0, d};
        return ipfmt_pkg::CH_HEX_A + {4'd0, d} - 8'd10;
    endfunction

    state_t           state_reg, state_next;
    ipfmt_pkg::desc_t cur_reg, cur_next;
    logic [2:0]       idx_reg, idx_next;
    logic [1:0]       dig_reg, dig_next;
    logic             strobe_reg, strobe_next;
    logic             last_reg, last_next;
    logic             empty_reg, empty_next;
    logic [7:0]       char_reg, char_next;

    logic [7:0]  v4_byte, v4_byte_nx;
    dec_t        v4_dec;
    logic [3:0]  v4_digit;
    logic [15:0] grp, grp_nx, grp_skip;
    logic [3:0]  nib;
    logic [3:0]  skip_idx;
    logic        run_here;

    assign v4_byte    = byte_at(cur_reg.addr, idx_reg[1:0]);
    assign v4_byte_nx = byte_at(cur_reg.addr, idx_reg[1:0] + 2'd1);
    assign v4_dec     = to_decimal(v4_byte);
    assign grp        = grp_at(cur_reg.addr, idx_reg);
    assign grp_nx     = grp_at(cur_reg.addr, idx_reg + 3'd1);
    assign skip_idx   = {1'b0, idx_reg} + cur_reg.run_len;
    assign grp_skip   = grp_at(cur_reg.addr, skip_idx[2:0]);
    assign nib        = 4'(grp >> {dig_reg, 2'b00});
    assign run_here   = (cur_reg.run_len != 4'd0) && (idx_reg == cur_reg.run_start);

    always_comb
    begin
        unique case (dig_reg)
            2'd2:    v4_digit = {2'b00, v4_dec.hund};
            2'd1:    v4_digit = v4_dec.tens;
            default: v4_digit = v4_dec.ones;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        dig_next    = dig_reg;
        strobe_next = 1'b0;
        last_next   = 1'b0;
        empty_next  = 1'b0;
        char_next   = ipfmt_pkg::CH_NUL;
        pop         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    idx_next = '0;
                    dig_next = dec_lead(byte_at(head.addr, 2'd0));
                    unique case (head.kind)
                        ipfmt_pkg::KIND_V4: state_next = ST_V4_DIG;
                        ipfmt_pkg::KIND_V6: state_next = ST_V6_OPEN;
                        default:            state_next = ST_EMPTY;
                    endcase
                end
            end
            ST_EMPTY:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                empty_next  = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_V4_DIG:
            begin
                strobe_next = 1'b1;
                char_next   = ipfmt_pkg::CH_ZERO + {4'd0, v4_digit};
                if (dig_reg != 2'd0)
                    dig_next = dig_reg - 2'd1;
                else if (idx_reg[1:0] == 2'd3)
                begin
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_V4_DOT;
            end
            ST_V4_DOT:
            begin
                strobe_next = 1'b1;
                char_next   = ipfmt_pkg::CH_DOT;
                idx_next    = idx_reg + 3'd1;
                dig_next    = dec_lead(v4_byte_nx);
                state_next  = ST_V4_DIG;
            end
            ST_V6_OPEN:
            begin
                strobe_next = 1'b1;
                char_next   = ipfmt_pkg::CH_LBRACK;
                dig_next    = hex_lead(grp);
                state_next  = run_here ? ST_V6_LEAD : ST_V6_HEX;
            end
            ST_V6_LEAD:
            begin
                // contraction at group 0 needs its own leading colon
                strobe_next = 1'b1;
                char_next   = ipfmt_pkg::CH_COLON;
                state_next  = ST_V6_DCOL;
            end
            ST_V6_HEX:
            begin
                strobe_next = 1'b1;
                char_next   = hex_char(nib);
                if (dig_reg != 2'd0)
                    dig_next = dig_reg - 2'd1;
                else if (idx_reg == 3'd7)
                    state_next = ST_V6_CLOSE;
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    dig_next   = hex_lead(grp_nx);
                    state_next = ST_V6_SEP;
                end
            end
            ST_V6_SEP:
            begin
                strobe_next = 1'b1;
                char_next   = ipfmt_pkg::CH_COLON;
                state_next  = run_here ? ST_V6_DCOL : ST_V6_HEX;
            end
            ST_V6_DCOL:
            begin
                strobe_next = 1'b1;
                char_next   = ipfmt_pkg::CH_COLON;
                if (skip_idx[3])
                    state_next = ST_V6_CLOSE;
                else
                begin
                    idx_next   = skip_idx[2:0];
                    dig_next   = hex_lead(grp_skip);
                    state_next = ST_V6_HEX;
                end
            end
            ST_V6_CLOSE:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                char_next   = ipfmt_pkg::CH_RBRACK;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        idx_reg   <= idx_next;
        dig_reg   <= dig_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
    end

    assign strobe     = strobe_reg;
    assign text_char  = char_reg;
    assign last_char  = last_reg;
    assign empty_text = empty_reg;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && empty_reg |-> last_reg && char_reg == ipfmt_pkg::CH_NUL)
        else $error("empty word not a single final NUL");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |=> !strobe_reg)
        else $error("character right after final character");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> strobe_reg == 1'b0)
        else $error("pop overlapped with text output");

    a_text_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !empty_reg |-> char_reg != ipfmt_pkg::CH_NUL)
        else $error("NUL inside address text");

endmodule
